@@ sv/spq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, request codes and controller command type for the stable
// sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // queue geometry
  localparam int unsigned DEPTH      = 32;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned PRIO_WIDTH = 32;
  localparam int unsigned CNT_WIDTH  = $clog2(DEPTH + 1);

  // request operation codes
  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // register request and compare mask
    logic exec;     // update the slot row and load the result register
  } cmd_t;

endpackage

@@ sv/spq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Two-state sequencer: takes a request, then executes it once the result
// register is free, and tracks the result valid flag.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // result register can take a new result this cycle
  assign out_free = !out_valid_q || out_ready_i;

  // command decode
  always_comb begin
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec    = (state_q == S_EXEC) && out_free;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // checks
  a_exec_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> (!out_valid_q || out_ready_i))
    else $error("exec while result register is held");

  a_capture_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == S_EXEC))
    else $error("captured request not moved to exec");

endmodule

@@ sv/spq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// Row of sorted slot cells with one priority comparator per cell, request
// registers, entry counter and result register.
// ----------------------------------------------------------------------------
module spq_datapath import spq_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cmd_t                         cmd_i,
  input  logic [1:0]                   op_i,
  input  logic [DATA_WIDTH-1:0]        data_in_i,
  input  logic signed [PRIO_WIDTH-1:0] priority_req_i,
  output logic [DATA_WIDTH-1:0]        data_out_o,
  output logic                         data_valid_o,
  output logic                         overflow_o,
  output logic [CNT_WIDTH-1:0]         entry_count_o,
  output logic                         is_empty_o
);

  // slot row, slot 0 is the head
  logic [DATA_WIDTH-1:0]        slot_data_q [DEPTH];
  logic signed [PRIO_WIDTH-1:0] slot_prio_q [DEPTH];
  logic [DATA_WIDTH-1:0]        slot_data_d [DEPTH];
  logic signed [PRIO_WIDTH-1:0] slot_prio_d [DEPTH];

  // request registers
  op_e                          op_q;
  logic [DATA_WIDTH-1:0]        data_q;
  logic signed [PRIO_WIDTH-1:0] prio_q;
  logic [DEPTH-1:0]             ins_q, ins_d, ins_prev;

  logic [CNT_WIDTH-1:0] count_q, count_d;
  logic                 full, empty;
  logic                 do_enq, do_deq;

  assign full   = (count_q == CNT_WIDTH'(DEPTH));
  assign empty  = (count_q == '0);
  assign do_enq = (op_q == OP_ENQ) && !full;
  assign do_deq = (op_q == OP_DEQ) && !empty;

  // insert mask: bit g set when the new entry goes ahead of cell g, toward the head
  assign ins_prev = {ins_q[DEPTH-2:0], 1'b0};

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0]        up_data, dn_data;
    logic signed [PRIO_WIDTH-1:0] up_prio, dn_prio;

    // comparator of this cell
    assign ins_d[g] = (CNT_WIDTH'(g) >= count_q) || (priority_req_i > slot_prio_q[g]);

    // neighbor toward the head
    if (g == 0) begin : g_head
      assign up_data = data_q;
      assign up_prio = prio_q;
    end else begin : g_mid
      assign up_data = slot_data_q[g-1];
      assign up_prio = slot_prio_q[g-1];
    end

    // neighbor toward the tail
    if (g == DEPTH - 1) begin : g_tail
      assign dn_data = slot_data_q[g];
      assign dn_prio = slot_prio_q[g];
    end else begin : g_body
      assign dn_data = slot_data_q[g+1];
      assign dn_prio = slot_prio_q[g+1];
    end

    // cell next value
    always_comb begin
      slot_data_d[g] = slot_data_q[g];
      slot_prio_d[g] = slot_prio_q[g];
      if (do_enq && ins_q[g]) begin
        if (ins_prev[g]) begin
          slot_data_d[g] = up_data;
          slot_prio_d[g] = up_prio;
        end else begin
          slot_data_d[g] = data_q;
          slot_prio_d[g] = prio_q;
        end
      end else if (do_deq) begin
        slot_data_d[g] = dn_data;
        slot_prio_d[g] = dn_prio;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.exec) begin
        slot_data_q[g] <= slot_data_d[g];
        slot_prio_q[g] <= slot_prio_d[g];
      end
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(op_i);
      data_q <= data_in_i;
      prio_q <= priority_req_i;
      ins_q  <= ins_d;
    end
  end

  // entry counter
  always_comb begin
    count_d = count_q;
    unique case (op_q)
      OP_ENQ:   if (!full) count_d = count_q + CNT_WIDTH'(1);
      OP_DEQ:   if (!empty) count_d = count_q - CNT_WIDTH'(1);
      OP_PEEK:  count_d = count_q;
      OP_CLEAR: count_d = '0;
      default:  count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      data_valid_o  <= ((op_q == OP_DEQ) || (op_q == OP_PEEK)) && !empty;
      data_out_o    <= (((op_q == OP_DEQ) || (op_q == OP_PEEK)) && !empty) ?
                       slot_data_q[0] : '0;
      overflow_o    <= (op_q == OP_ENQ) && full;
      entry_count_o <= count_d;
      is_empty_o    <= (count_d == '0);
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_WIDTH'(DEPTH))
    else $error("entry count above depth");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (op_q == OP_CLEAR)) |=> (count_q == '0))
    else $error("clear left entries");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (op_q == OP_ENQ) && !full) |=>
      (count_q == $past(count_q) + CNT_WIDTH'(1)))
    else $error("enqueue did not add one entry");

endmodule

@@ sv/stable_priority_queue.sv @@
// the request is registered when accepted, and the result register is loaded in the exec state once the output is free
// each request takes a compare step, then a shift/update step
// the compare step checks the request priority against all 32 slot cells at once
// a held result stalls the update cycle; no new request is taken until the update is done
// reset: asynchronous, active low; empties the queue and drops any pending result
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded sorted priority queue: enqueue keeps equal priorities in arrival
// order, dequeue and peek return the head, clear empties the queue.
// ----------------------------------------------------------------------------
module stable_priority_queue import spq_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic [DATA_WIDTH-1:0]        data_in_i,
  input  logic signed [PRIO_WIDTH-1:0] priority_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [DATA_WIDTH-1:0]        data_out_o,
  output logic                         data_valid_o,
  output logic                         overflow_o,
  output logic [CNT_WIDTH-1:0]         entry_count_o,
  output logic                         is_empty_o
);

  cmd_t cmd;

  // sequencer
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // slot row and result register
  spq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (op_i),
    .data_in_i      (data_in_i),
    .priority_req_i (priority_req_i),
    .data_out_o     (data_out_o),
    .data_valid_o   (data_valid_o),
    .overflow_o     (overflow_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o)
  );

endmodule

@@ tb/spq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Watches the request and result channels of the stable priority queue,
// keeps its own sorted copy of the queue contents, works out the answer to
// every accepted request and compares each accepted result with the oldest
// answer still waiting.
// ----------------------------------------------------------------------------
module spq_checker import spq_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [1:0]                   op_i,
  input  logic [DATA_WIDTH-1:0]        data_in_i,
  input  logic signed [PRIO_WIDTH-1:0] priority_req_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [DATA_WIDTH-1:0]        data_out_i,
  input  logic                         data_valid_i,
  input  logic                         overflow_i,
  input  logic [CNT_WIDTH-1:0]         entry_count_i,
  input  logic                         is_empty_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           overflows_o,
  output int                           empty_reads_o
);

  typedef struct packed {
    logic [DATA_WIDTH-1:0] data;
    logic                  hit;
    logic                  overflow;
    logic [CNT_WIDTH-1:0]  count;
    logic                  empty;
  } queue_answer_t;

  localparam int REPORT_LIMIT = 10;

  // shadow copy of the sorted slot row, slot 0 is the head
  logic [DATA_WIDTH-1:0]        shadow_data [DEPTH];
  logic signed [PRIO_WIDTH-1:0] shadow_prio [DEPTH];
  int                           shadow_count;

  queue_answer_t answers_q [$];
  int            failures;
  int            overflows;
  int            empty_reads;

  // apply one request to the shadow queue and return its answer
  function automatic queue_answer_t apply_request(
    input op_e                          op,
    input logic [DATA_WIDTH-1:0]        d,
    input logic signed [PRIO_WIDTH-1:0] p
  );
    queue_answer_t a;
    int            pos;
    int            i;
    a = '0;
    case (op)
      OP_ENQ: begin
        if (shadow_count >= DEPTH) begin
          a.overflow = 1'b1;
          overflows++;
        end else begin
          // insert ahead of the first strictly lower priority
          pos = shadow_count;
          for (i = 0; i < shadow_count; i++) begin
            if (p > shadow_prio[i]) begin
              pos = i;
              break;
            end
          end
          for (i = shadow_count; i > pos; i--) begin
            shadow_data[i] = shadow_data[i-1];
            shadow_prio[i] = shadow_prio[i-1];
          end
          shadow_data[pos] = d;
          shadow_prio[pos] = p;
          shadow_count++;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (shadow_count > 0) begin
          a.data = shadow_data[0];
          a.hit  = 1'b1;
          if (op == OP_DEQ) begin
            for (i = 1; i < shadow_count; i++) begin
              shadow_data[i-1] = shadow_data[i];
              shadow_prio[i-1] = shadow_prio[i];
            end
            shadow_count--;
          end
        end else begin
          empty_reads++;
        end
      end
      default: begin
        shadow_count = 0;
      end
    endcase
    a.count = CNT_WIDTH'(shadow_count);
    a.empty = (shadow_count == 0);
    return a;
  endfunction

  // compare one accepted result against the oldest waiting answer
  task automatic check_result();
    queue_answer_t want;
    queue_answer_t got;
    string         bad;
    got = '{data: data_out_i, hit: data_valid_i, overflow: overflow_i,
            count: entry_count_i, empty: is_empty_i};
    if (answers_q.size() == 0) begin
      failures++;
      if (failures <= REPORT_LIMIT) begin
        $display("[%0t] unexpected result: data=%h valid=%b ovf=%b count=%0d empty=%b",
                 $realtime, got.data, got.hit, got.overflow, got.count, got.empty);
      end
    end else begin
      want = answers_q.pop_front();
      bad  = "";
      if (got.data !== want.data)         bad = {bad, " data_out"};
      if (got.hit !== want.hit)           bad = {bad, " data_valid"};
      if (got.overflow !== want.overflow) bad = {bad, " overflow"};
      if (got.count !== want.count)       bad = {bad, " entry_count"};
      if (got.empty !== want.empty)       bad = {bad, " is_empty"};
      if (bad != "") begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("[%0t] mismatch in%s", $realtime, bad);
          $display("  expected data_out=%h data_valid=%b overflow=%b count=%0d empty=%b",
                   want.data, want.hit, want.overflow, want.count, want.empty);
          $display("  actual   data_out=%h data_valid=%b overflow=%b count=%0d empty=%b",
                   got.data, got.hit, got.overflow, got.count, got.empty);
        end
      end
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      answers_q.delete();
      shadow_count = 0;
      failures     = 0;
      overflows    = 0;
      empty_reads  = 0;
      fail_count_o  <= 0;
      pending_o     <= 0;
      overflows_o   <= 0;
      empty_reads_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_result();
      end
      if (in_valid_i && in_ready_i) begin
        answers_q.push_back(apply_request(op_e'(op_i), data_in_i, priority_req_i));
      end
      fail_count_o  <= failures;
      pending_o     <= answers_q.size();
      overflows_o   <= overflows;
      empty_reads_o <= empty_reads;
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the stable priority queue with a short directed sequence and then
// random fill, drain and mixed sequences under bursty requests and an
// irregular result stall; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module tb import spq_pkg::*; ();

  localparam int          RANDOM_ITEMS = 1650;
  localparam int          HOLD_CYCLES  = 300;
  localparam int unsigned LIMIT_NS     = 2_000_000;

  localparam logic [31:0] PRIO_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] PRIO_MIN = 32'h8000_0000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  op_e                          op_i;
  logic [DATA_WIDTH-1:0]        data_in_i;
  logic signed [PRIO_WIDTH-1:0] priority_req_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [DATA_WIDTH-1:0]        data_out_o;
  logic                         data_valid_o;
  logic                         overflow_o;
  logic [CNT_WIDTH-1:0]         entry_count_o;
  logic                         is_empty_o;

  int   fail_count;
  int   pending;
  int   overflows;
  int   empty_reads;

  logic hold_go = 1'b0;
  int   burst_left = 8;
  int   sent = 0;
  int   op_hist [4];

  always #2 clk_i = ~clk_i;

  stable_priority_queue u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .data_in_i      (data_in_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_out_o     (data_out_o),
    .data_valid_o   (data_valid_o),
    .overflow_o     (overflow_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o)
  );

  spq_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .op_i           (op_i),
    .data_in_i      (data_in_i),
    .priority_req_i (priority_req_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_out_i     (data_out_o),
    .data_valid_i   (data_valid_o),
    .overflow_i     (overflow_o),
    .entry_count_i  (entry_count_o),
    .is_empty_i     (is_empty_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .overflows_o    (overflows),
    .empty_reads_o  (empty_reads)
  );

  // hard stop in case the queue hangs
  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // result side: stall patterns in stretches, plus a long hold on request
  initial begin : receiver
    int stretch;
    int mode;
    int tick;
    stretch = 0;
    mode    = 0;
    tick    = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_go = 1'b0;
        out_ready_i <= 1'b1;
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(3);
          stretch = $urandom_range(10, 80);
        end
        stretch--;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(3) != 0);
          2: out_ready_i <= ($urandom_range(3) == 0);
          default: begin
            tick++;
            out_ready_i <= tick[2];
          end
        endcase
      end
    end
  end

  // offer one request and wait for it to be taken; gaps fall between bursts
  task automatic push_request(input op_e op, input logic [31:0] d, input logic [31:0] p);
    int gap;
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    op_i           <= op;
    data_in_i      <= d;
    priority_req_i <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    op_hist[op]++;
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
    end
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
  endtask

  // priorities: a narrow band for ties, the extremes, or anything
  function automatic logic [31:0] pick_priority();
    int roll;
    int v;
    roll = $urandom_range(99);
    if (roll < 50) begin
      v = int'($urandom_range(6)) - 3;
      return v;
    end else if (roll < 65) begin
      case ($urandom_range(4))
        0: return PRIO_MAX;
        1: return PRIO_MIN;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom;
  endfunction

  // op mix for each sequence shape
  function automatic op_e pick_op(input int shape);
    int roll;
    roll = $urandom_range(99);
    case (shape)
      0: return (roll < 85) ? OP_ENQ : ((roll < 95) ? OP_DEQ : OP_PEEK);
      1: return (roll < 75) ? OP_DEQ : ((roll < 90) ? OP_PEEK : OP_ENQ);
      2: begin
        if (roll < 45) return OP_ENQ;
        if (roll < 80) return OP_DEQ;
        if (roll < 95) return OP_PEEK;
        return OP_CLEAR;
      end
      default: return op_e'($urandom_range(3));
    endcase
  endfunction

  // main stimulus
  initial begin : stimulus
    int shape;
    int len;
    int n;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    op_i           = OP_ENQ;
    data_in_i      = '0;
    priority_req_i = '0;
    foreach (op_hist[i]) op_hist[i] = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // head reads and clear on an empty queue
    push_request(OP_PEEK,  32'h0, 32'h0);
    push_request(OP_DEQ,   32'h0, 32'h0);
    push_request(OP_CLEAR, 32'h0, 32'h0);
    // extreme priorities and data words
    push_request(OP_ENQ, 32'hFFFF_FFFF, PRIO_MIN);
    push_request(OP_ENQ, 32'h0000_0000, PRIO_MAX);
    // equal priorities keep arrival order
    push_request(OP_ENQ, 32'h0000_00A1, 32'd5);
    push_request(OP_ENQ, 32'h0000_00B2, 32'd5);
    push_request(OP_ENQ, 32'h0000_00C3, 32'd5);
    push_request(OP_ENQ, 32'h0000_00D4, 32'hFFFF_FFFF);
    push_request(OP_ENQ, 32'h0000_00E5, 32'h0);
    push_request(OP_PEEK, 32'h0, 32'h0);
    push_request(OP_DEQ,  32'h0, 32'h0);
    push_request(OP_DEQ,  32'h0, 32'h0);
    push_request(OP_DEQ,  32'h0, 32'h0);
    push_request(OP_PEEK, 32'h0, 32'h0);
    // the top of the priority range, and a tie at its bottom
    push_request(OP_ENQ, 32'h5555_5555, PRIO_MAX);
    push_request(OP_ENQ, 32'hAAAA_AAAA, PRIO_MIN);
    // clear a populated queue, then read it empty
    push_request(OP_CLEAR, 32'h0, 32'h0);
    push_request(OP_DEQ,   32'h0, 32'h0);
    push_request(OP_ENQ,   32'h1234_5678, 32'hFFFF_FFFF);
    push_request(OP_DEQ,   32'h0, 32'h0);
    push_request(OP_PEEK,  32'h0, 32'h0);
    drain_results();

    // fill past full while results are held back, so the input stalls
    hold_go = 1'b1;
    repeat (45) push_request(OP_ENQ, $urandom, pick_priority());
    drain_results();

    // random sequences of random shape
    n = 0;
    while (n < RANDOM_ITEMS) begin
      shape = $urandom_range(9);
      len   = $urandom_range(5, 50);
      if (shape <= 2) begin
        shape = 0;
      end else if (shape <= 4) begin
        shape = 1;
      end else if (shape <= 7) begin
        shape = 2;
      end else if (shape == 9) begin
        push_request(OP_CLEAR, $urandom, $urandom);
        n++;
        shape = 2;
      end
      if (n > RANDOM_ITEMS / 2 && n <= RANDOM_ITEMS / 2 + 50 && shape == 0) begin
        hold_go = 1'b1;
      end
      repeat (len) begin
        push_request(pick_op(shape), $urandom, (shape == 3) ? $urandom : pick_priority());
        n++;
      end
      if ($urandom_range(15) == 0) begin
        drain_results();
      end
    end

    // wind down
    drain_results();
    repeat (16) @(posedge clk_i);
    $display("covered %0d requests: %0d enqueue, %0d dequeue, %0d peek, %0d clear",
             sent, op_hist[OP_ENQ], op_hist[OP_DEQ], op_hist[OP_PEEK], op_hist[OP_CLEAR]);
    $display("enqueues dropped on a full queue: %0d, head reads of an empty queue: %0d",
             overflows, empty_reads);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
